// ===== rtl/grid_bitmap_dilation_unit_assert.svh =====
// Assertion macros shared by the grid bitmap dilation unit.
`ifndef GRID_BITMAP_DILATION_UNIT_ASSERT_SVH
`define GRID_BITMAP_DILATION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbd_pkg.sv =====
// Package with the word types and neighbourhood masks of the grid bitmap dilation unit.
package gbd_pkg;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [63:0] word_bits;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_index;
    logic [63:0] out_bits;
    logic        out_last;
  } out_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // 5x5 offset masks, bit (row_offset+2)*5 + (column_offset+2).
  localparam logic [24:0] CORE_MASK = 25'h00739C0;
  localparam logic [24:0] LINE_MASK = 25'h1504415;
  localparam int unsigned NB_SIZE = 25;
  localparam int unsigned NB_SPAN = 5;
  localparam int unsigned NB_REACH = 2;

endpackage

// ===== rtl/gbd_front.sv =====
// Front end: accepts grid words, keeps the grid store and queues complete grids.
module gbd_front import gbd_pkg::*; #(
  parameter int unsigned GRID_SIDE  = 19,
  parameter int unsigned WORD_COUNT = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  in_word_t                   item,
  output logic                       push,
  output logic [WORD_COUNT*64-1:0]   snapshot
);

  localparam int unsigned CAP = WORD_COUNT * 64;
  localparam int unsigned SQ  = GRID_SIDE * GRID_SIDE;
  localparam logic [CAP-1:0] VALID_MASK = (SQ >= CAP) ? {CAP{1'b1}} : ~({CAP{1'b1}} << SQ);

  logic [CAP-1:0] grid_store;
  logic [CAP-1:0] grid_store_next;

  for (genvar w = 0; w < WORD_COUNT; w++) begin : g_word
    assign snapshot[w*64 +: 64] = (accept && item.word_index == 3'(w))
                                ? (item.word_bits & VALID_MASK[w*64 +: 64])
                                : grid_store[w*64 +: 64];
  end

  assign push = accept && item.last_word;
  assign grid_store_next = push ? '0 : snapshot;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_store <= '0;
    end else begin
      grid_store <= grid_store_next;
    end
  end

endmodule

// ===== rtl/gbd_queue.sv =====
// Two-entry queue of complete grids between the front end and the back end.
module gbd_queue import gbd_pkg::*; #(
  parameter int unsigned WIDTH = 384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output queue_status_t    status
);

  `include "grid_bitmap_dilation_unit_assert.svh"

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `GBD_ASSERT_NOW(a_no_overflow, clk, rst, push, !status.full || pop, "grid queue overflow")
  `GBD_ASSERT_NOW(a_no_underflow, clk, rst, pop, !status.empty, "grid queue underflow")
  `GBD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count != 2'd3, "grid queue count out of range")

endmodule

// ===== rtl/gbd_back.sv =====
// Back end: dilates a queued grid and emits its result words in order.
module gbd_back import gbd_pkg::*; #(
  parameter int unsigned GRID_SIDE  = 19,
  parameter int unsigned WORD_COUNT = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               mode,
  input  queue_status_t            status,
  input  logic [WORD_COUNT*64-1:0] grid,
  output logic                     pop,
  output logic                     result_valid,
  output out_word_t                result
);

  `include "grid_bitmap_dilation_unit_assert.svh"

  localparam int unsigned CAP = WORD_COUNT * 64;
  localparam int unsigned SQ  = GRID_SIDE * GRID_SIDE;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  back_state_t    state;
  back_state_t    state_next;
  logic [2:0]     word_count;
  logic [CAP-1:0] dilated;
  logic [CAP-1:0] result_bits;
  logic           last_out;

  for (genvar t = 0; t < CAP; t++) begin : g_square
    if (t < SQ) begin : g_inside
      localparam int R = t / GRID_SIDE;
      localparam int C = t % GRID_SIDE;
      logic [NB_SIZE-1:0] nb;
      for (genvar a = 0; a < NB_SPAN; a++) begin : g_row
        for (genvar b = 0; b < NB_SPAN; b++) begin : g_col
          localparam int SR = R + a - NB_REACH;
          localparam int SC = C + b - NB_REACH;
          localparam int S  = SR * GRID_SIDE + SC;
          if (SR >= 0 && SR < GRID_SIDE && SC >= 0 && SC < GRID_SIDE && S < CAP) begin : g_src
            assign nb[a*NB_SPAN + b] = grid[S];
          end else begin : g_none
            assign nb[a*NB_SPAN + b] = 1'b0;
          end
        end
      end
      assign dilated[t] = (|(nb & CORE_MASK))
                        | ((|mode) & (|(nb & LINE_MASK)))
                        | (mode[1] & (|(nb & ~(CORE_MASK | LINE_MASK))));
    end else begin : g_outside
      assign dilated[t] = 1'b0;
    end
  end

  assign last_out = (word_count == 3'(WORD_COUNT - 1));
  assign pop      = (state == ST_IDLE) && !status.empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!status.empty) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_count <= 3'd0;
    end else begin
      state <= state_next;
      if (pop) begin
        word_count <= 3'd0;
      end else if (state == ST_EMIT) begin
        word_count <= word_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_bits <= dilated;
    end else if (state == ST_EMIT) begin
      result_bits <= result_bits >> 64;
    end
  end

  assign result_valid      = (state == ST_EMIT);
  assign result.out_index  = word_count;
  assign result.out_bits   = result_bits[63:0];
  assign result.out_last   = last_out;

  `GBD_ASSERT_NEXT(a_pop_emits, clk, rst, pop, result_valid && word_count == 3'd0,
                   "grid taken without starting its emit")
  `GBD_ASSERT_NEXT(a_last_ends, clk, rst, result_valid && last_out, !result_valid,
                   "emit runs past its final word")

endmodule

// ===== rtl/grid_bitmap_dilation_unit.sv =====
// Top level of the grid bitmap dilation unit.
// A word is taken on every cycle in which start is high and busy is low, so a grid
// streams in at one word per cycle while busy stays low. The word marked last closes
// the grid, which then waits in a two-grid queue; the back end pops it, registers its
// dilated words and emits WORD_COUNT result words on consecutive cycles, each shown
// for one cycle with result_valid high. The receiver cannot stall the results. Busy
// is high only while two finished grids wait for the back end. The dilation mode
// register may be written only while no grid is queued or being emitted.
module grid_bitmap_dilation_unit import gbd_pkg::*; #(
  parameter int unsigned GRID_SIDE  = 19,
  parameter int unsigned WORD_COUNT = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_word_t   item,
  output logic       result_valid,
  output out_word_t  result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  localparam int unsigned CAP = WORD_COUNT * 64;

  logic           dilation_mode_q;
  logic [1:0]     dilation_mode;
  logic           accept;
  logic           push;
  logic           pop;
  logic [CAP-1:0] snapshot;
  logic [CAP-1:0] head;
  queue_status_t  status;

  assign dilation_mode_q = cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      dilation_mode <= 2'd0;
    end else if (dilation_mode_q) begin
      dilation_mode <= cfg_data;
    end
  end

  assign busy   = status.full;
  assign accept = start && !busy;

  gbd_front #(
    .GRID_SIDE  (GRID_SIDE),
    .WORD_COUNT (WORD_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .push     (push),
    .snapshot (snapshot)
  );

  gbd_queue #(
    .WIDTH (CAP)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (snapshot),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  gbd_back #(
    .GRID_SIDE  (GRID_SIDE),
    .WORD_COUNT (WORD_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .mode         (dilation_mode),
    .status       (status),
    .grid         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== test/tb_grid_bitmap_dilation_unit.sv =====
// Testbench that checks the grid bitmap dilation unit against a predictor, with directed and random grids.
`timescale 1ns / 100ps

module tb_grid_bitmap_dilation_unit;
  import gbd_pkg::*;

  localparam int SIDE = 19;
  localparam int WORDS = 6;
  localparam int SQUARES = SIDE * SIDE;
  localparam int SETTLE = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PLAN_ROWS = 18;
  localparam int PHASE_WORDS = 48;

  typedef enum logic [1:0] {
    MODE_3X3   = 2'd0,
    MODE_LINES = 2'd1,
    MODE_5X5   = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef logic [WORDS-1:0][63:0] grid_t;

  typedef struct packed {
    logic     set_mode;
    mode_e    mode;
    in_word_t w;
    logic     typed;
    grid_t    want;
  } plan_row_t;

  localparam logic [63:0] ALL = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam grid_t FULL_GRID = {64'h0000_01FF_FFFF_FFFF, {5{ALL}}};
  localparam grid_t CORNER_GRID = {{5{64'h0}}, 64'h0000_0000_0018_0003};

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, MODE_3X3,   '{3'd0, 64'd0, 1'b1},                  1'b1, '0},
    '{1'b0, MODE_3X3,   '{3'd0, ALL, 1'b0},                    1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd1, ALL, 1'b0},                    1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd2, ALL, 1'b0},                    1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd3, ALL, 1'b0},                    1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd4, ALL, 1'b0},                    1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd5, ALL, 1'b1},                    1'b1, FULL_GRID},
    '{1'b0, MODE_3X3,   '{3'd0, 64'd1, 1'b1},                  1'b1, CORNER_GRID},
    '{1'b0, MODE_3X3,   '{3'd6, ALL, 1'b0},                    1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd7, 64'h0123_4567_89AB_CDEF, 1'b1}, 1'b1, '0},
    '{1'b1, MODE_LINES, '{3'd2, 64'd1 << 52, 1'b1},            1'b0, '0},
    '{1'b1, MODE_5X5,   '{3'd2, 64'd1 << 52, 1'b1},            1'b0, '0},
    '{1'b0, MODE_5X5,   '{3'd5, 64'd1 << 40, 1'b1},            1'b0, '0},
    '{1'b1, MODE_SPARE, '{3'd0, 64'd1 << 18, 1'b1},            1'b0, '0},
    '{1'b0, MODE_SPARE, '{3'd5, 64'd1 << 22, 1'b1},            1'b0, '0},
    '{1'b1, MODE_3X3,   '{3'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0}, 1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd1, 64'h5555_5555_5555_5555, 1'b0}, 1'b0, '0},
    '{1'b0, MODE_3X3,   '{3'd3, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1}, 1'b0, '0}
  };

  localparam mode_e PHASE_MODE [4] = '{MODE_LINES, MODE_SPARE, MODE_5X5, MODE_3X3};
  localparam int PHASE_IDLE [4] = '{0, 48, 0, 16};

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  in_word_t item;
  logic result_valid;
  out_word_t result;
  logic cfg_we;
  logic [1:0] cfg_data;

  grid_t held_grid;
  mode_e held_mode;
  out_word_t pending_words[$];
  out_word_t due_word;
  int mismatches;
  int quiet_cycles;

  grid_bitmap_dilation_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] square_mask(int k);
    int span;
    span = SQUARES - k * 64;
    if (span <= 0) return '0;
    if (span >= 64) return '1;
    return (64'd1 << span) - 64'd1;
  endfunction

  function automatic bit reaches(int dr, int dc, mode_e m);
    int ar;
    int ac;
    ar = (dr < 0) ? -dr : dr;
    ac = (dc < 0) ? -dc : dc;
    if (ar <= 1 && ac <= 1) return 1'b1;
    if (m == MODE_5X5 || m == MODE_SPARE) return 1'b1;
    if (m == MODE_LINES) return (ar != 1) && (ac != 1);
    return 1'b0;
  endfunction

  function automatic grid_t grow(grid_t g, mode_e m);
    grid_t o;
    int sq;
    int tr;
    int tc;
    int t;
    o = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        sq = r * SIDE + c;
        if (!g[sq / 64][sq % 64]) continue;
        for (int dr = -2; dr <= 2; dr++) begin
          for (int dc = -2; dc <= 2; dc++) begin
            tr = r + dr;
            tc = c + dc;
            if (tr < 0 || tr >= SIDE || tc < 0 || tc >= SIDE) continue;
            if (!reaches(dr, dc, m)) continue;
            t = tr * SIDE + tc;
            o[t / 64][t % 64] = 1'b1;
          end
        end
      end
    end
    return o;
  endfunction

  task automatic take_word(in_word_t w, bit typed, grid_t want);
    grid_t grown;
    out_word_t r;
    if (w.word_index < WORDS)
      held_grid[w.word_index] = w.word_bits & square_mask(int'(w.word_index));
    if (w.last_word) begin
      grown = typed ? want : grow(held_grid, held_mode);
      for (int k = 0; k < WORDS; k++) begin
        r.out_index = 3'(k);
        r.out_bits = grown[k];
        r.out_last = (k == WORDS - 1);
        pending_words.push_back(r);
      end
      held_grid = '0;
    end
  endtask

  task automatic send_word(in_word_t w, int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(mode_e m);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    held_mode = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word", 64'd0, result.out_bits);
      end else begin
        due_word = pending_words.pop_front();
        if (result.out_index !== due_word.out_index)
          note_mismatch("out_index", 64'(due_word.out_index), 64'(result.out_index));
        if (result.out_bits !== due_word.out_bits)
          note_mismatch("out_bits", due_word.out_bits, result.out_bits);
        if (result.out_last !== due_word.out_last)
          note_mismatch("out_last", 64'(due_word.out_last), 64'(result.out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int count;
    int kind;
    bit paused;
    bit in_order;
    in_word_t w;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    held_grid = '0;
    held_mode = MODE_3X3;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].set_mode) write_mode(PLAN[i].mode);
      send_word(PLAN[i].w, 0);
      take_word(PLAN[i].w, PLAN[i].typed, PLAN[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_mode(PHASE_MODE[phase]);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        in_order = ($urandom_range(0, 3) != 0);
        count = in_order ? WORDS : $urandom_range(1, WORDS);
        for (int k = 0; k < count; k++) begin
          w.word_index = in_order ? 3'(k) : 3'($urandom_range(0, 7));
          kind = $urandom_range(0, 19);
          if (kind < 10) begin
            w.word_bits = '0;
            repeat ($urandom_range(1, 3)) w.word_bits[$urandom_range(0, 63)] = 1'b1;
          end else if (kind < 15) begin
            w.word_bits = {$urandom, $urandom};
          end else if (kind < 18) begin
            w.word_bits = '0;
          end else begin
            w.word_bits = '1;
          end
          w.last_word = (k == count - 1);
          send_word(w, PHASE_IDLE[phase]);
          take_word(w, 1'b0, '0);
          sent++;
        end
        if (phase == 1 && !paused && sent >= PHASE_WORDS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
